FILE: rtl/core/bct_pkg.sv
// shared types and constants for the box collision test
// no dependencies
package bct_pkg;

    localparam int unsigned COORD_W     = 32;
    localparam int unsigned HALF_W      = 31;
    localparam int unsigned MAG_W       = 32;
    localparam int unsigned ROOT_W      = 33;
    localparam int unsigned DIFF_W      = 34;
    localparam int unsigned NUM_W       = 65;
    localparam int unsigned QUOT_W      = 32;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic OP_BOX    = 1'b0;
    localparam logic OP_CIRCLE = 1'b1;

    // one classified word between front and back
    typedef struct packed {
        logic              op;
        logic              box_hit;
        logic              neg_x;
        logic              neg_y;
        logic [MAG_W-1:0]  adx;
        logic [MAG_W-1:0]  ady;
        logic [HALF_W-1:0] ha_x;
        logic [HALF_W-1:0] ha_y;
        logic [HALF_W-1:0] hb_x;
        logic [HALF_W-1:0] hb_y;
    } t_item;

    // side data carried alongside the square roots
    typedef struct packed {
        logic             op;
        logic             box_hit;
        logic             neg_x;
        logic             neg_y;
        logic [MAG_W-1:0] adx;
        logic [MAG_W-1:0] ady;
    } t_side;

    // side data carried alongside the dividers
    typedef struct packed {
        logic hit;
        logic zero;
        logic neg_x;
        logic neg_y;
    } t_tail;

endpackage

FILE: rtl/core/bct_front.sv
// front stage: offsets, box interval test and operand selection
// depends on bct_pkg
module bct_front import bct_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic                      i_op,
    input  logic signed [COORD_W-1:0] i_my_center_x,
    input  logic signed [COORD_W-1:0] i_my_center_y,
    input  logic        [HALF_W-1:0]  i_my_half_x,
    input  logic        [HALF_W-1:0]  i_my_half_y,
    input  logic signed [COORD_W-1:0] i_other_center_x,
    input  logic signed [COORD_W-1:0] i_other_center_y,
    input  logic        [HALF_W-1:0]  i_other_half_x,
    input  logic        [HALF_W-1:0]  i_other_half_y,
    input  logic        [HALF_W-1:0]  i_other_radius,
    input  logic                      i_q_ready,
    output logic                      o_q_push,
    output t_item                     o_q_item
);

    logic   r_valid;
    t_item  r_item;
    t_item  n_item;
    logic   accept;
    logic   load;

    logic signed [COORD_W:0]   dx, dy;
    logic signed [COORD_W+1:0] my_lo_x, my_hi_x, ot_lo_x, ot_hi_x;
    logic signed [COORD_W+1:0] my_lo_y, my_hi_y, ot_lo_y, ot_hi_y;
    logic apart;

    assign load   = !r_valid || i_q_ready;
    assign accept = i_push && load;
    assign o_full = !load;

    always_comb begin
        dx = COORD_W'(0) + ({i_other_center_x[COORD_W-1], i_other_center_x}
             - {i_my_center_x[COORD_W-1], i_my_center_x});
        dy = ({i_other_center_y[COORD_W-1], i_other_center_y}
             - {i_my_center_y[COORD_W-1], i_my_center_y});

        my_lo_x = (COORD_W+2)'(i_my_center_x) - $signed({3'b000, i_my_half_x});
        my_hi_x = (COORD_W+2)'(i_my_center_x) + $signed({3'b000, i_my_half_x});
        ot_lo_x = (COORD_W+2)'(i_other_center_x) - $signed({3'b000, i_other_half_x});
        ot_hi_x = (COORD_W+2)'(i_other_center_x) + $signed({3'b000, i_other_half_x});
        my_lo_y = (COORD_W+2)'(i_my_center_y) - $signed({3'b000, i_my_half_y});
        my_hi_y = (COORD_W+2)'(i_my_center_y) + $signed({3'b000, i_my_half_y});
        ot_lo_y = (COORD_W+2)'(i_other_center_y) - $signed({3'b000, i_other_half_y});
        ot_hi_y = (COORD_W+2)'(i_other_center_y) + $signed({3'b000, i_other_half_y});
        // closed intervals, touching counts as a hit
        apart = (my_hi_x < ot_lo_x) || (my_lo_x > ot_hi_x)
             || (my_hi_y < ot_lo_y) || (my_lo_y > ot_hi_y);

        n_item.op      = i_op;
        n_item.box_hit = !apart;
        n_item.neg_x   = dx[COORD_W];
        n_item.neg_y   = dy[COORD_W];
        n_item.adx     = dx[COORD_W] ? MAG_W'(-dx) : MAG_W'(dx);
        n_item.ady     = dy[COORD_W] ? MAG_W'(-dy) : MAG_W'(dy);
        n_item.ha_x    = i_my_half_x;
        n_item.ha_y    = i_my_half_y;
        // a circle is a box whose half-extent length is the radius
        if (i_op == OP_CIRCLE) begin
            n_item.hb_x = i_other_radius;
            n_item.hb_y = '0;
        end else begin
            n_item.hb_x = i_other_half_x;
            n_item.hb_y = i_other_half_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_q_push = r_valid && i_q_ready;
    assign o_q_item = r_item;

endmodule

FILE: rtl/core/bct_queue.sv
// short register queue between front and back
// depends on bct_pkg
module bct_queue import bct_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]  r_count, n_count;
    logic           do_push, do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr    = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd    = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on push");
    a_pop_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not shrink on pop");
    a_ptr_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("queue pointers differ while empty");

endmodule

FILE: rtl/core/bct_sqrt.sv
// pipelined floor square root, one root bit per stage
// depends on bct_pkg
module bct_sqrt import bct_pkg::*; #(
    parameter int unsigned RW = ROOT_W
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_sq,
    output logic [RW-1:0]   o_root
);

    localparam int unsigned W = 2 * RW + 1;

    logic [W-1:0]  r_rem  [RW];
    logic [RW-1:0] r_root [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int unsigned B = RW - 1 - k;
        logic [W-1:0]  rem_in, trial;
        logic [RW-1:0] root_in;

        if (k == 0) begin : g_first
            assign rem_in  = W'(i_sq);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
        assign trial = (W'(root_in) << (B + 1)) | (W'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[k]  <= rem_in - trial;
                    r_root[k] <= root_in | (RW'(1) << B);
                end else begin
                    r_rem[k]  <= rem_in;
                    r_root[k] <= root_in;
                end
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

FILE: rtl/core/bct_div.sv
// pipelined restoring divider with an early overflow check
// depends on bct_pkg
module bct_div import bct_pkg::*; #(
    parameter int unsigned NW = NUM_W,
    parameter int unsigned DW = ROOT_W,
    parameter int unsigned QW = QUOT_W
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quot,
    output logic          o_sat
);

    localparam int unsigned HW = NW - QW;

    logic          r_sat [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_lo  [QW+1];

    // quotient of 2^QW or more saturates anyway
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= ({{DW{1'b0}}, i_num[NW-1:QW]} >= {{HW{1'b0}}, i_den});
            r_rem[0] <= DW'(i_num[NW-1:QW]);
            r_lo[0]  <= i_num[QW-1:0];
            r_den[0] <= i_den;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0] rem2;
        logic        ge;
        assign rem2 = {r_rem[k-1], r_lo[k-1][QW-1]};
        assign ge   = (rem2 >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? DW'(rem2 - {1'b0, r_den[k-1]}) : DW'(rem2);
                r_lo[k]  <= {r_lo[k-1][QW-2:0], ge};
                r_den[k] <= r_den[k-1];
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    assign o_quot = r_lo[QW];
    assign o_sat  = r_sat[QW];

endmodule

FILE: rtl/core/bct_back.sv
// back pipeline: lengths, flag, push scale and saturation
// depends on bct_pkg, bct_sqrt, bct_div
module bct_back import bct_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_item                     i_item,
    output logic                      o_take,
    output logic                      o_valid,
    input  logic                      i_pop,
    output logic                      o_overlap,
    output logic signed [COORD_W-1:0] o_push_x,
    output logic signed [COORD_W-1:0] o_push_y
);

    localparam int unsigned SQ_LAT = ROOT_W;
    localparam int unsigned DV_LAT = QUOT_W + 1;
    localparam int unsigned LAT    = 1 + SQ_LAT + 1 + 1 + DV_LAT + 1;

    logic en;
    logic r_vld [LAT];

    assign en      = !r_vld[LAT-1] || i_pop;
    assign o_take  = en && i_valid;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // squares
    logic [2*ROOT_W-1:0] r0_sq_d, r0_sq_a, r0_sq_b;
    t_side               r0_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_sq_d <= (2*ROOT_W)'(i_item.adx) * (2*ROOT_W)'(i_item.adx)
                     + (2*ROOT_W)'(i_item.ady) * (2*ROOT_W)'(i_item.ady);
            r0_sq_a <= (2*ROOT_W)'(i_item.ha_x) * (2*ROOT_W)'(i_item.ha_x)
                     + (2*ROOT_W)'(i_item.ha_y) * (2*ROOT_W)'(i_item.ha_y);
            r0_sq_b <= (2*ROOT_W)'(i_item.hb_x) * (2*ROOT_W)'(i_item.hb_x)
                     + (2*ROOT_W)'(i_item.hb_y) * (2*ROOT_W)'(i_item.hb_y);
            r0_side <= '{op: i_item.op, box_hit: i_item.box_hit, neg_x: i_item.neg_x,
                         neg_y: i_item.neg_y, adx: i_item.adx, ady: i_item.ady};
        end
    end

    logic [ROOT_W-1:0] d_len, len_a, len_b;

    bct_sqrt #(.RW(ROOT_W)) u_sqrt_d (.i_clk, .i_en(en), .i_sq(r0_sq_d), .o_root(d_len));
    bct_sqrt #(.RW(ROOT_W)) u_sqrt_a (.i_clk, .i_en(en), .i_sq(r0_sq_a), .o_root(len_a));
    bct_sqrt #(.RW(ROOT_W)) u_sqrt_b (.i_clk, .i_en(en), .i_sq(r0_sq_b), .o_root(len_b));

    t_side r_sd [SQ_LAT];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r0_side;
            for (int i = 1; i < SQ_LAT; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
        end
    end

    // lengths to flag and signed difference
    logic [ROOT_W-1:0]  lsum;
    logic [DIFF_W-1:0]  diff;
    t_side              sd;
    logic               hit;

    assign sd   = r_sd[SQ_LAT-1];
    assign lsum = len_a + len_b;
    assign diff = {1'b0, lsum} - {1'b0, d_len};
    assign hit  = (sd.op == OP_CIRCLE) ? (d_len <= lsum) : sd.box_hit;

    logic [ROOT_W-1:0] r1_dist, r1_adiff;
    logic [MAG_W-1:0]  r1_adx, r1_ady;
    t_tail             r1_tail;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dist       <= d_len;
            r1_adiff      <= diff[DIFF_W-1] ? ROOT_W'(-diff) : ROOT_W'(diff);
            r1_adx        <= sd.adx;
            r1_ady        <= sd.ady;
            r1_tail.hit   <= hit;
            // boxes apart or coincident centers push nothing
            r1_tail.zero  <= (d_len == '0) || ((sd.op == OP_BOX) && !sd.box_hit);
            r1_tail.neg_x <= sd.neg_x ^ diff[DIFF_W-1] ^ sd.op;
            r1_tail.neg_y <= sd.neg_y ^ diff[DIFF_W-1] ^ sd.op;
        end
    end

    // numerators
    logic [NUM_W-1:0]  r2_num_x, r2_num_y;
    logic [ROOT_W-1:0] r2_dist;
    t_tail             r2_tail;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_num_x <= NUM_W'(r1_adx) * NUM_W'(r1_adiff);
            r2_num_y <= NUM_W'(r1_ady) * NUM_W'(r1_adiff);
            r2_dist  <= r1_dist;
            r2_tail  <= r1_tail;
        end
    end

    logic [QUOT_W-1:0] quot_x, quot_y;
    logic              sat_x, sat_y;

    bct_div #(.NW(NUM_W), .DW(ROOT_W), .QW(QUOT_W)) u_div_x (
        .i_clk, .i_en(en), .i_num(r2_num_x), .i_den(r2_dist),
        .o_quot(quot_x), .o_sat(sat_x)
    );
    bct_div #(.NW(NUM_W), .DW(ROOT_W), .QW(QUOT_W)) u_div_y (
        .i_clk, .i_en(en), .i_num(r2_num_y), .i_den(r2_dist),
        .o_quot(quot_y), .o_sat(sat_y)
    );

    t_tail r_dd [DV_LAT];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dd[0] <= r2_tail;
            for (int i = 1; i < DV_LAT; i++) begin
                r_dd[i] <= r_dd[i-1];
            end
        end
    end

    // saturate and apply sign
    t_tail             tl;
    logic [QUOT_W-1:0] lim_x, lim_y, mag_x, mag_y;

    always_comb begin
        tl    = r_dd[DV_LAT-1];
        lim_x = tl.neg_x ? {1'b1, {(QUOT_W-1){1'b0}}} : {1'b0, {(QUOT_W-1){1'b1}}};
        lim_y = tl.neg_y ? {1'b1, {(QUOT_W-1){1'b0}}} : {1'b0, {(QUOT_W-1){1'b1}}};
        mag_x = (sat_x || quot_x > lim_x) ? lim_x : quot_x;
        mag_y = (sat_y || quot_y > lim_y) ? lim_y : quot_y;
    end

    logic                      r_overlap;
    logic signed [COORD_W-1:0] r_push_x, r_push_y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_overlap <= tl.hit;
            if (tl.zero) begin
                r_push_x <= '0;
                r_push_y <= '0;
            end else begin
                r_push_x <= tl.neg_x ? COORD_W'(-mag_x) : COORD_W'(mag_x);
                r_push_y <= tl.neg_y ? COORD_W'(-mag_y) : COORD_W'(mag_y);
            end
        end
    end

    assign o_overlap = r_overlap;
    assign o_push_x  = r_push_x;
    assign o_push_y  = r_push_y;

endmodule

FILE: rtl/core/box_collision_test_2d.sv
// Box collision test, 2D, signed Q16.16.
// Input side is a queue: drive the operands and raise i_push; a word is
// taken on a rising edge with i_push high and o_full low.
// Result side is a queue too: while o_empty is low the oldest result sits
// on o_overlap, o_push_x and o_push_y, and i_pop on such an edge takes it.
// op 0 tests box against box, op 1 box against circle.
// One word enters per cycle while o_full is low. A front register
// classifies it (offsets, interval test) and hands it to a short queue;
// the back is a 70-stage pipeline (squares, 33-stage root pipelines,
// flag and numerator stages, 33-stage dividers, output register). A held
// result stalls the whole back pipeline; the front keeps taking words
// until the queue and front register fill, then o_full rises. Synchronous
// reset empties the queue and pipeline; no results are shown until new
// words arrive.
// depends on bct_pkg, bct_front, bct_queue, bct_back
module box_collision_test_2d import bct_pkg::*; #(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic                      i_op,
    input  logic signed [COORD_W-1:0] i_my_center_x,
    input  logic signed [COORD_W-1:0] i_my_center_y,
    input  logic        [HALF_W-1:0]  i_my_half_x,
    input  logic        [HALF_W-1:0]  i_my_half_y,
    input  logic signed [COORD_W-1:0] i_other_center_x,
    input  logic signed [COORD_W-1:0] i_other_center_y,
    input  logic        [HALF_W-1:0]  i_other_half_x,
    input  logic        [HALF_W-1:0]  i_other_half_y,
    input  logic        [HALF_W-1:0]  i_other_radius,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic                      o_overlap,
    output logic signed [COORD_W-1:0] o_push_x,
    output logic signed [COORD_W-1:0] o_push_y
);

    logic  q_ready, q_push, q_valid, q_pop, b_valid;
    t_item f_item, q_item;

    bct_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full,
        .i_op, .i_my_center_x, .i_my_center_y, .i_my_half_x, .i_my_half_y,
        .i_other_center_x, .i_other_center_y, .i_other_half_x, .i_other_half_y,
        .i_other_radius,
        .i_q_ready(q_ready), .o_q_push(q_push), .o_q_item(f_item)
    );

    bct_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_push(q_push), .i_item(f_item), .o_ready(q_ready),
        .i_pop(q_pop), .o_valid(q_valid), .o_item(q_item)
    );

    bct_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .i_item(q_item), .o_take(q_pop),
        .o_valid(b_valid), .i_pop,
        .o_overlap, .o_push_x, .o_push_y
    );

    assign o_empty = !b_valid;

endmodule
